// ===== rtl/core/ctb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types, constants and the sector step table of the Bezier tessellator.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int MAX_SECTORS  = 32;
  localparam int CFG_WIDTH    = 6;
  localparam int T_WIDTH      = 17;
  localparam int K_WIDTH      = $clog2(MAX_SECTORS);
  localparam int REM_WIDTH    = K_WIDTH;
  localparam int W_WIDTH      = 25;
  localparam logic [CFG_WIDTH-1:0] SECTOR_RESET = CFG_WIDTH'(10);

  typedef enum logic [1:0] {CMD_SEG, CMD_END, CMD_BAD} cmd_kind_t;
  typedef enum logic [1:0] {OK_POINT, OK_PASS, OK_ZERO} out_kind_t;
  typedef enum logic {BK_POINTS, BK_TAIL} back_state_t;

  typedef struct packed {
    cmd_kind_t                          kind;
    logic                               last;
    logic [CFG_WIDTH-1:0]               n;
    logic [3:0][COORD_WIDTH-1:0]        px;
    logic [3:0][COORD_WIDTH-1:0]        py;
  } cmd_t;

  typedef struct packed {
    out_kind_t                          okind;
    logic                               rl;
    logic [3:0][COORD_WIDTH-1:0]        px;
    logic [3:0][COORD_WIDTH-1:0]        py;
  } meta_t;

  typedef struct packed {
    logic [T_WIDTH-1:0]   q;
    logic [REM_WIDTH-1:0] r;
  } step_t;

  // floor(65536 / n) and 65536 mod n
  function automatic step_t sector_step(input logic [CFG_WIDTH-1:0] n);
    step_t s;
    unique case (n)
      6'd1:    s = '{17'd65536, 5'd0};
      6'd2:    s = '{17'd32768, 5'd0};
      6'd3:    s = '{17'd21845, 5'd1};
      6'd4:    s = '{17'd16384, 5'd0};
      6'd5:    s = '{17'd13107, 5'd1};
      6'd6:    s = '{17'd10922, 5'd4};
      6'd7:    s = '{17'd9362,  5'd2};
      6'd8:    s = '{17'd8192,  5'd0};
      6'd9:    s = '{17'd7281,  5'd7};
      6'd10:   s = '{17'd6553,  5'd6};
      6'd11:   s = '{17'd5957,  5'd9};
      6'd12:   s = '{17'd5461,  5'd4};
      6'd13:   s = '{17'd5041,  5'd3};
      6'd14:   s = '{17'd4681,  5'd2};
      6'd15:   s = '{17'd4369,  5'd1};
      6'd16:   s = '{17'd4096,  5'd0};
      6'd17:   s = '{17'd3855,  5'd1};
      6'd18:   s = '{17'd3640,  5'd16};
      6'd19:   s = '{17'd3449,  5'd5};
      6'd20:   s = '{17'd3276,  5'd16};
      6'd21:   s = '{17'd3120,  5'd16};
      6'd22:   s = '{17'd2978,  5'd20};
      6'd23:   s = '{17'd2849,  5'd9};
      6'd24:   s = '{17'd2730,  5'd16};
      6'd25:   s = '{17'd2621,  5'd11};
      6'd26:   s = '{17'd2520,  5'd16};
      6'd27:   s = '{17'd2427,  5'd7};
      6'd28:   s = '{17'd2340,  5'd16};
      6'd29:   s = '{17'd2259,  5'd25};
      6'd30:   s = '{17'd2184,  5'd16};
      6'd31:   s = '{17'd2114,  5'd2};
      6'd32:   s = '{17'd2048,  5'd0};
      default: s = '{17'd65536, 5'd0};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ctb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_front
// Collects control points and turns each path event into a queue command.
// ----------------------------------------------------------------------------
module ctb_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [ctb_pkg::COORD_WIDTH-1:0]     in_x,
  input  wire  [ctb_pkg::COORD_WIDTH-1:0]     in_y,
  input  wire                                 in_last,
  input  wire  [ctb_pkg::CFG_WIDTH-1:0]       sectors,
  input  wire                                 q_full,
  output logic                                push,
  output ctb_pkg::cmd_t                       cmd
);

  logic [2:0][ctb_pkg::COORD_WIDTH-1:0] held_x;
  logic [2:0][ctb_pkg::COORD_WIDTH-1:0] held_y;
  logic [1:0]                           phase;
  logic                                 started;
  logic                                 take;
  logic [ctb_pkg::CFG_WIDTH-1:0]        n_eff;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (sectors == '0) begin
      n_eff = ctb_pkg::CFG_WIDTH'(1);
    end else if (sectors > ctb_pkg::CFG_WIDTH'(ctb_pkg::MAX_SECTORS)) begin
      n_eff = ctb_pkg::CFG_WIDTH'(ctb_pkg::MAX_SECTORS);
    end else begin
      n_eff = sectors;
    end
  end

  always_comb begin
    cmd.kind  = ctb_pkg::CMD_SEG;
    cmd.last  = in_last;
    cmd.n     = n_eff;
    cmd.px    = {in_x, held_x[2], held_x[1], held_x[0]};
    cmd.py    = {in_y, held_y[2], held_y[1], held_y[0]};
    push      = 1'b0;
    if (take) begin
      priority if (!started) begin
        cmd.kind = ctb_pkg::CMD_END;
        push     = in_last;
      end else if (phase != 2'd2) begin
        cmd.kind = ctb_pkg::CMD_BAD;
        push     = in_last;
      end else begin
        push     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      phase   <= 2'd0;
      held_x  <= '0;
      held_y  <= '0;
    end else if (take) begin
      priority if (!started) begin
        phase <= 2'd0;
        if (!in_last) begin
          held_x[0] <= in_x;
          held_y[0] <= in_y;
          started   <= 1'b1;
        end
      end else if (phase != 2'd2) begin
        if (in_last) begin
          started <= 1'b0;
          phase   <= 2'd0;
        end else begin
          held_x[phase + 2'd1] <= in_x;
          held_y[phase + 2'd1] <= in_y;
          phase                <= phase + 2'd1;
        end
      end else begin
        phase <= 2'd0;
        if (in_last) begin
          started <= 1'b0;
        end else begin
          held_x[0] <= in_x;
          held_y[0] <= in_y;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ctb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ctb_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  ctb_pkg::cmd_t  wr_cmd,
  input  wire            pop,
  output logic           full,
  output logic           valid,
  output ctb_pkg::cmd_t  head
);

  ctb_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_pop;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ctb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_back
// Sector sequencer and Bernstein evaluation pipeline with output register.
// ----------------------------------------------------------------------------
module ctb_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 q_valid,
  input  ctb_pkg::cmd_t                       head,
  output logic                                pop,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ctb_pkg::COORD_WIDTH-1:0]     out_x,
  output logic [ctb_pkg::COORD_WIDTH-1:0]     out_y,
  output logic                                run_last,
  output logic                                curve_end,
  output logic                                bad_count
);

  localparam int CW   = ctb_pkg::COORD_WIDTH;
  localparam int TW   = ctb_pkg::T_WIDTH;
  localparam int WW   = ctb_pkg::W_WIDTH;
  localparam int KW   = ctb_pkg::K_WIDTH;
  localparam int NW   = ctb_pkg::CFG_WIDTH;
  localparam int RW   = ctb_pkg::REM_WIDTH;
  localparam int SQW  = 2 * TW;
  localparam int CUW  = 3 * TW + 2;
  localparam int PW   = WW + 1 + CW;
  localparam int SW   = PW + 2;
  localparam int RSW  = SW - 24;
  localparam logic [TW-1:0]  T_ONE = TW'(65536);
  localparam logic [CUW-1:0] WHALF = CUW'(1) << 23;
  localparam logic [SW-1:0]  SHALF = SW'(1) << 23;

  ctb_pkg::back_state_t state, state_next;
  logic [KW-1:0]  k, k_next;
  logic [TW-1:0]  t, t_next;
  logic [RW-1:0]  r, r_next;
  logic           adv, issue, last_pt, is_seg;
  logic [TW-1:0]  cur_t;
  logic [RW-1:0]  cur_r;
  logic [NW-1:0]  rs;
  logic           wrap;
  ctb_pkg::step_t stp;
  ctb_pkg::meta_t meta_in;

  logic           v1, v2, v3, v4;
  ctb_pkg::meta_t m1, m2, m3, m4;
  logic [TW-1:0]  t1, u1, t2, u2;
  logic [SQW-1:0] tt2, uu2, tu2;
  logic [WW-1:0]  w3 [4];
  logic [CUW-1:0] c0, c1, c2, c3;
  logic signed [PW-1:0] prx [4];
  logic signed [PW-1:0] pry [4];
  logic signed [SW-1:0] sx, sy;
  logic signed [RSW-1:0] rx, ry;
  logic [CW-1:0]  fx, fy;

  assign adv     = !out_valid || out_ready;
  assign is_seg  = (head.kind == ctb_pkg::CMD_SEG);
  assign last_pt = ({1'b0, k} == head.n - NW'(1));
  assign stp     = ctb_pkg::sector_step(head.n);
  assign cur_t   = (k == '0) ? '0 : t;
  assign cur_r   = (k == '0) ? RW'(head.n >> 1) : r;
  assign rs      = {1'b0, cur_r} + {1'b0, stp.r};
  assign wrap    = (rs >= head.n);

  always_comb begin
    state_next = state;
    if (adv && q_valid) begin
      unique case (state)
        ctb_pkg::BK_POINTS: begin
          if (is_seg && last_pt && head.last) begin
            state_next = ctb_pkg::BK_TAIL;
          end
        end
        ctb_pkg::BK_TAIL: state_next = ctb_pkg::BK_POINTS;
        default:          state_next = ctb_pkg::BK_POINTS;
      endcase
    end
  end

  always_comb begin
    issue        = adv && q_valid;
    pop          = 1'b0;
    k_next       = k;
    t_next       = t;
    r_next       = r;
    meta_in.px   = head.px;
    meta_in.py   = head.py;
    meta_in.okind = ctb_pkg::OK_PASS;
    meta_in.rl   = 1'b1;
    unique case (state)
      ctb_pkg::BK_POINTS: begin
        unique case (head.kind)
          ctb_pkg::CMD_SEG: begin
            meta_in.okind = ctb_pkg::OK_POINT;
            meta_in.rl    = last_pt && !head.last;
            pop           = issue && last_pt && !head.last;
            if (issue) begin
              k_next = last_pt ? '0 : k + KW'(1);
              t_next = cur_t + stp.q + TW'(wrap);
              r_next = wrap ? RW'(rs - head.n) : RW'(rs);
            end
          end
          ctb_pkg::CMD_BAD: begin
            meta_in.okind = ctb_pkg::OK_ZERO;
            pop           = issue;
          end
          default: pop = issue;
        endcase
      end
      default: pop = issue;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctb_pkg::BK_POINTS;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
    t <= t_next;
    r <= r_next;
  end

  always_comb begin
    c0 = CUW'(uu2) * CUW'(u2);
    c1 = CUW'(tu2) * CUW'(u2);
    c2 = CUW'(tt2) * CUW'(u2);
    c3 = CUW'(tt2) * CUW'(t2);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prx[i] = $signed({1'b0, w3[i]}) * $signed(m3.px[i]);
      pry[i] = $signed({1'b0, w3[i]}) * $signed(m3.py[i]);
    end
  end

  logic signed [PW-1:0] qx [4];
  logic signed [PW-1:0] qy [4];

  always_comb begin
    sx = SW'(qx[0]) + SW'(qx[1]) + SW'(qx[2]) + SW'(qx[3]) + $signed(SHALF);
    sy = SW'(qy[0]) + SW'(qy[1]) + SW'(qy[2]) + SW'(qy[3]) + $signed(SHALF);
    rx = RSW'(sx >>> 24);
    ry = RSW'(sy >>> 24);
    if (rx[RSW-1:CW-1] == '0 || rx[RSW-1:CW-1] == '1) begin
      fx = rx[CW-1:0];
    end else begin
      fx = rx[RSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    if (ry[RSW-1:CW-1] == '0 || ry[RSW-1:CW-1] == '1) begin
      fy = ry[CW-1:0];
    end else begin
      fy = ry[RSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= meta_in;
      t1  <= cur_t;
      u1  <= T_ONE - cur_t;
      m2  <= m1;
      t2  <= t1;
      u2  <= u1;
      tt2 <= SQW'(t1) * SQW'(t1);
      uu2 <= SQW'(u1) * SQW'(u1);
      tu2 <= SQW'(t1) * SQW'(u1);
      m3  <= m2;
      w3[0] <= WW'((c0 + WHALF) >> 24);
      w3[1] <= WW'(((c1 << 1) + c1 + WHALF) >> 24);
      w3[2] <= WW'(((c2 << 1) + c2 + WHALF) >> 24);
      w3[3] <= WW'((c3 + WHALF) >> 24);
      m4  <= m3;
      qx  <= prx;
      qy  <= pry;
      unique case (m4.okind)
        ctb_pkg::OK_POINT: begin
          out_x <= fx;
          out_y <= fy;
        end
        ctb_pkg::OK_PASS: begin
          out_x <= m4.px[3];
          out_y <= m4.py[3];
        end
        default: begin
          out_x <= '0;
          out_y <= '0;
        end
      endcase
      run_last  <= m4.rl;
      curve_end <= (m4.okind == ctb_pkg::OK_PASS);
      bad_count <= (m4.okind == ctb_pkg::OK_ZERO);
    end
  end

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (q_valid && state == ctb_pkg::BK_POINTS && is_seg) |-> ({1'b0, k} < head.n))
    else $error("sector index past sector count");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (q_valid && is_seg && k != '0) |-> ({1'b0, r} < head.n))
    else $error("step remainder not below sector count");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && curve_end) |-> (run_last && !bad_count))
    else $error("curve end without run last");

  a_bad_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_count) |-> (run_last && out_x == '0 && out_y == '0))
    else $error("error result malformed");

endmodule
`default_nettype wire

// ===== rtl/core/cubic_bezier_tessellator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator
// Chained cubic Bezier path tessellator, fixed point Q16.8 coordinates.
// ----------------------------------------------------------------------------
// Control points are taken one per cycle while the two-entry command queue
// has room. A point that completes a segment yields sector_count results
// (clamped to 1..32), one per cycle from the evaluation pipeline while
// out_ready does not stall it; a last point adds one more result.
module cubic_bezier_tessellator (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [ctb_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [ctb_pkg::COORD_WIDTH-1:0]     in_x,
  input  wire  [ctb_pkg::COORD_WIDTH-1:0]     in_y,
  input  wire                                 in_last,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ctb_pkg::COORD_WIDTH-1:0]     out_x,
  output logic [ctb_pkg::COORD_WIDTH-1:0]     out_y,
  output logic                                run_last,
  output logic                                curve_end,
  output logic                                bad_count
);

  logic [ctb_pkg::CFG_WIDTH-1:0] sector_count;
  logic                          q_full;
  logic                          q_valid;
  logic                          push;
  logic                          pop;
  ctb_pkg::cmd_t                 cmd;
  ctb_pkg::cmd_t                 head;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= ctb_pkg::SECTOR_RESET;
    end else if (cfg_wr_en) begin
      sector_count <= cfg_wr_data;
    end
  end

  ctb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_last  (in_last),
    .sectors  (sector_count),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd)
  );

  ctb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (cmd),
    .pop    (pop),
    .full   (q_full),
    .valid  (q_valid),
    .head   (head)
  );

  ctb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .run_last  (run_last),
    .curve_end (curve_end),
    .bad_count (bad_count)
  );

endmodule
`default_nettype wire

// ===== sim/cubic_bezier_tessellator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_tb
// Self-checking regression for the chained cubic Bezier tessellator.
// ----------------------------------------------------------------------------
// Control points go in over a valid/ready channel. A behavioral model of the
// path state and the Bernstein evaluation predicts every tessellated point, and
// each output transfer is checked field by field against the oldest prediction.
// Directed paths cover coordinate extremes, lone and unfinished paths, and
// sector count extremes. Random paths follow with random idling on both sides,
// a long receiver stall and a sender pause until the output drains.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_tb;

  localparam int CW = ctb_pkg::COORD_WIDTH;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          rl;
    logic          ce;
    logic          bad;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [ctb_pkg::CFG_WIDTH-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_x = '0;
  logic [CW-1:0] in_y = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CW-1:0] out_x, out_y;
  logic run_last, curve_end, bad_count;

  cubic_bezier_tessellator u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .run_last(run_last),
    .curve_end(curve_end), .bad_count(bad_count)
  );

  always #5 clk = ~clk;

  // model state
  longint ctrl_x[3];
  longint ctrl_y[3];
  int unsigned held_pts;
  bit path_open;
  logic [ctb_pkg::CFG_WIDTH-1:0] sectors;

  point_t pending_pts[$];
  int errors;
  int points_seen;
  int paths_sent;
  int hold_requests = 0;
  int hold_seen;
  int draw_wait;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic queue_expected(input point_t p);
    pending_pts = {pending_pts, p};
  endtask

  function automatic longint sext(input logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [CW-1:0] round_sat(input longint s);
    longint v;
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -(64'sd1 <<< (CW - 1));
    v = (s + (64'sd1 <<< 23)) >>> 24;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  task automatic predict_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic last);
    longint unsigned n, t, u, k;
    longint w0, w1, w2, w3, px, py;
    point_t p;
    n = sectors;
    if (n < 1) n = 1;
    if (n > ctb_pkg::MAX_SECTORS) n = ctb_pkg::MAX_SECTORS;
    px = sext(x);
    py = sext(y);
    if (!path_open) begin
      if (last) begin
        p = '{x, y, 1'b1, 1'b1, 1'b0};
        queue_expected(p);
      end else begin
        ctrl_x[0] = px;
        ctrl_y[0] = py;
        path_open = 1'b1;
      end
      held_pts = 0;
    end else if (held_pts < 2) begin
      if (last) begin
        p = '{'0, '0, 1'b1, 1'b0, 1'b1};
        queue_expected(p);
        path_open = 1'b0;
        held_pts = 0;
      end else begin
        ctrl_x[held_pts + 1] = px;
        ctrl_y[held_pts + 1] = py;
        held_pts++;
      end
    end else begin
      for (k = 0; k < n; k++) begin
        t = (k * 65536 + n / 2) / n;
        u = 65536 - t;
        w0 = longint'((u * u * u + (64'd1 << 23)) >> 24);
        w1 = longint'((3 * t * u * u + (64'd1 << 23)) >> 24);
        w2 = longint'((3 * t * t * u + (64'd1 << 23)) >> 24);
        w3 = longint'((t * t * t + (64'd1 << 23)) >> 24);
        p.x = round_sat(w0 * ctrl_x[0] + w1 * ctrl_x[1] + w2 * ctrl_x[2] + w3 * px);
        p.y = round_sat(w0 * ctrl_y[0] + w1 * ctrl_y[1] + w2 * ctrl_y[2] + w3 * py);
        p.rl = (!last && k == n - 1);
        p.ce = 1'b0;
        p.bad = 1'b0;
        queue_expected(p);
      end
      if (last) begin
        p = '{x, y, 1'b1, 1'b1, 1'b0};
        queue_expected(p);
        path_open = 1'b0;
      end else begin
        ctrl_x[0] = px;
        ctrl_y[0] = py;
      end
      held_pts = 0;
    end
  endtask

  // valid stays high after the transfer until the next item or an idle call
  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic last, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(x, y, last);
    if (last) paths_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sectors(input logic [ctb_pkg::CFG_WIDTH-1:0] v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sectors = v;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(0, 65535)) - CW'(32768);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_path(input int segs);
    send_point(rand_coord(), rand_coord(), segs == 0);
    for (int s = 0; s < segs; s++)
      for (int j = 0; j < 3; j++)
        send_point(rand_coord(), rand_coord(), s == segs - 1 && j == 2);
  endtask

  // directed: extremes, lone point, unfinished segments
  task automatic test_directed();
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_point(mx, mn, 1'b1);
    send_point(mx, mx, 1'b0);
    send_point(mn, mn, 1'b0);
    send_point(mx, mx, 1'b0);
    send_point(mn, mn, 1'b0);
    send_point(mn, mx, 1'b0);
    send_point(mx, mn, 1'b0);
    send_point(mx, mx, 1'b1);
    send_point('0, '0, 1'b0);
    send_point(mx, mx, 1'b1);
    send_point('1, '1, 1'b0);
    send_point(mx, mn, 1'b0);
    send_point(mn, mx, 1'b1);
    send_point('0, '0, 1'b0);
    send_point(mx, mx, 1'b0);
    send_point(mx, mx, 1'b0);
    send_point(mx, mx, 1'b1);
  endtask

  task automatic test_sector_extremes();
    write_sectors(6'd1);
    send_path(2);
    write_sectors(6'd0);
    send_path(1);
    write_sectors(6'd63);
    send_path(1);
    write_sectors(6'd32);
    send_path(1);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 3) == 0)
        write_sectors(6'($urandom_range(0, 63)));
      if ($urandom_range(0, 5) == 0) begin
        // broken path: one or two points then last
        send_point(rand_coord(), rand_coord(), 1'b0);
        if ($urandom_range(0, 1)) send_point(rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), 1'b1);
        sent += 3;
      end else begin
        automatic int segs = $urandom_range(0, 3);
        send_path(segs);
        sent += 1 + 3 * segs;
      end
    end
  endtask

  task automatic test_backpressure();
    write_sectors(6'd32);
    hold_requests++;
    for (int i = 0; i < 10; i++)
      send_point(rand_coord(), rand_coord(), i == 9, 1'b1);
    wait_drain();
    send_path(2);
  endtask

  // output side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        report("result with nothing expected");
      end else begin
        automatic point_t e = pending_pts.pop_front();
        points_seen++;
        if (out_x !== e.x) report($sformatf("out_x %h want %h", out_x, e.x));
        if (out_y !== e.y) report($sformatf("out_y %h want %h", out_y, e.y));
        if (run_last !== e.rl) report($sformatf("run_last %b want %b", run_last, e.rl));
        if (curve_end !== e.ce) report($sformatf("curve_end %b want %b", curve_end, e.ce));
        if (bad_count !== e.bad) report($sformatf("bad_count %b want %b", bad_count, e.bad));
      end
    end
  end

  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (out_valid) begin
      draw_wait = $urandom_range(0, 4);
      if (draw_wait != 0) begin
        out_ready <= 1'b0;
        stall_left <= draw_wait - 1;
      end
    end
  end

  initial begin
    #2ms;
    $display("cubic_bezier_tessellator regression: fail");
    $finish;
  end

  initial begin
    errors = 0;
    points_seen = 0;
    paths_sent = 0;
    held_pts = 0;
    path_open = 1'b0;
    sectors = ctb_pkg::SECTOR_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sector_extremes();
    test_random();
    test_backpressure();
    wait_drain();
    $display("Covered %0d paths and %0d checked points, sector counts 0..63,",
             paths_sent, points_seen);
    $display("lone and unfinished paths, and a long output stall.");
    if (errors == 0) begin
      $display("cubic_bezier_tessellator regression: pass");
    end else begin
      $display("cubic_bezier_tessellator regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ctb_pkg.sv
rtl/core/ctb_front.sv
rtl/core/ctb_queue.sv
rtl/core/ctb_back.sv
rtl/core/cubic_bezier_tessellator.sv
sim/cubic_bezier_tessellator_tb.sv
